// ===== src/qwir_pkg.sv =====
// Shared types and codes for the queue with insert and rotate.
package qwir_pkg;

  localparam int WORD_W = 32;
  localparam int POS_W  = 5;
  localparam int OCC_W  = 5;

  typedef enum logic [2:0] {
    OP_ENQ = 3'd0,
    OP_DEQ = 3'd1,
    OP_INS = 3'd2,
    OP_ROR = 3'd3,
    OP_ROL = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_DROP     = 3'd3,
    ST_NOCHANGE = 3'd4
  } status_t;

  // Command broadcast to every cell once the operation has been checked.
  typedef enum logic [2:0] {
    ACT_NONE   = 3'd0,
    ACT_APPEND = 3'd1,
    ACT_POP    = 3'd2,
    ACT_INSERT = 3'd3,
    ACT_ROR    = 3'd4,
    ACT_ROL    = 3'd5
  } act_t;

  typedef struct packed {
    logic [2:0]               op;
    logic signed [WORD_W-1:0] data_in;
    logic [POS_W-1:0]         position;
  } cmd_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] data_out;
    status_t                  status;
    logic [OCC_W-1:0]         occupancy;
  } res_t;

endpackage

// ===== src/qwir_cell.sv =====
// One storage cell of the queue row; loads its word from a neighbor, data_in or the pick bus, or holds.
module qwir_cell import qwir_pkg::*; #(
  parameter int CW  = 5,
  parameter int IDX = 0
) (
  input  logic                     clk,
  input  act_t                     act,
  input  logic [CW-1:0]            count,
  input  logic [CW-1:0]            pos,
  input  logic [CW-1:0]            pick_idx,
  input  logic signed [WORD_W-1:0] data_in,
  input  logic signed [WORD_W-1:0] pick_in,
  input  logic signed [WORD_W-1:0] left,
  input  logic signed [WORD_W-1:0] right,
  output logic signed [WORD_W-1:0] val,
  output logic signed [WORD_W-1:0] tap
);

  localparam logic [CW-1:0] ID      = CW'(IDX);
  localparam logic [CW-1:0] ID_NEXT = CW'(IDX + 1);

  logic signed [WORD_W-1:0] val_next;

  always_comb begin
    val_next = val;
    case (act)
      ACT_APPEND: begin
        if (ID == count) val_next = data_in;
      end
      ACT_POP: begin
        val_next = right;
      end
      ACT_INSERT: begin
        if (ID == pos) val_next = data_in;
        else if (ID > pos) val_next = left;
      end
      ACT_ROR: begin
        if (ID == pos) val_next = pick_in;
        else if (ID > pos && ID < count) val_next = left;
      end
      ACT_ROL: begin
        if (ID_NEXT == count) val_next = pick_in;
        else if (ID >= pos && ID_NEXT < count) val_next = right;
      end
      default: val_next = val;
    endcase
  end

  always_ff @(posedge clk) begin
    val <= val_next;
  end

  // feeds the shared pick bus (tail word for rotate right, position word for left)
  assign tap = (ID == pick_idx) ? val : '0;

endmodule

// ===== src/queue_with_insert_and_rotate.sv =====
// Queue with insert and rotate: a row of cells in front-to-tail order.
//
// Usage: one command transaction on cmd (op, data_in, position) gives one
// result transaction on res (data_out, status, occupancy). Ops: enqueue at
// the tail, dequeue the front, insert at a position clamped to the
// occupancy, rotate right or left by one the span from position to tail.
// A transaction is taken on a rising edge with valid high and stall low.
//
// Timing: the result is registered and appears in the cycle after the command
// is accepted. Throughput: one command per cycle while cmd_stall is low; every
// cell picks its next word from its neighbors, data_in or the pick bus in the same cycle.
//
// Reset (rst, synchronous) empties the queue and drops any pending result;
// cmd_stall is high while rst is high. Cell contents are not cleared; only
// entries below the occupancy are ever read.
//
// When res_stall holds the pending result, cmd_stall rises in the same
// cycle and no new command is taken until the result leaves.
module queue_with_insert_and_rotate import qwir_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_stall,
  input  cmd_t cmd,
  output logic res_valid,
  input  logic res_stall,
  output res_t res
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (CW > POS_W) ? CW : POS_W;
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [CW-1:0]            cnt;
  logic [CW-1:0]            cnt_next;
  logic                     cmd_fire;
  logic [PW-1:0]            pos_ext;
  logic [PW-1:0]            cnt_ext;
  logic [CW-1:0]            pos_c;
  logic [CW-1:0]            span;
  logic [CW-1:0]            pick_idx;
  logic                     full;
  logic                     rot_ok;
  act_t                     act;
  status_t                  st;
  res_t                     res_next;
  logic signed [WORD_W-1:0] pick_word;
  logic signed [WORD_W-1:0] vals [DEPTH];
  logic signed [WORD_W-1:0] taps [DEPTH];

  assign cmd_stall = rst || (res_valid && res_stall);
  assign cmd_fire  = cmd_valid && !cmd_stall;

  assign pos_ext  = PW'(cmd.position);
  assign cnt_ext  = PW'(cnt);
  assign pos_c    = (pos_ext > cnt_ext) ? cnt : CW'(pos_ext);
  assign span     = cnt - pos_c;
  assign full     = (cnt == FULL_CNT);
  assign rot_ok   = (span >= CW'(2));
  assign pick_idx = (op_t'(cmd.op) == OP_ROR) ? cnt - CW'(1) : pos_c;

  always_comb begin
    act      = ACT_NONE;
    st       = ST_NOCHANGE;
    cnt_next = cnt;
    case (op_t'(cmd.op))
      OP_ENQ: begin
        if (full) st = ST_FULL;
        else begin
          st       = ST_OK;
          act      = ACT_APPEND;
          cnt_next = cnt + CW'(1);
        end
      end
      OP_DEQ: begin
        if (cnt == '0) st = ST_EMPTY;
        else begin
          st       = ST_OK;
          act      = ACT_POP;
          cnt_next = cnt - CW'(1);
        end
      end
      OP_INS: begin
        if (full) begin
          if (pos_c == cnt) st = ST_FULL;
          else begin
            st  = ST_DROP;
            act = ACT_INSERT;
          end
        end else begin
          st       = ST_OK;
          act      = ACT_INSERT;
          cnt_next = cnt + CW'(1);
        end
      end
      OP_ROR: begin
        if (rot_ok) begin
          st  = ST_OK;
          act = ACT_ROR;
        end
      end
      OP_ROL: begin
        if (rot_ok) begin
          st  = ST_OK;
          act = ACT_ROL;
        end
      end
      default: st = ST_NOCHANGE;
    endcase
    if (!cmd_fire) begin
      act      = ACT_NONE;
      cnt_next = cnt;
    end
  end

  always_comb begin
    pick_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      pick_word = pick_word | taps[i];
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [WORD_W-1:0] left_w;
    logic signed [WORD_W-1:0] right_w;
    if (g == 0) begin : g_first
      assign left_w = vals[g];
    end else begin : g_mid_l
      assign left_w = vals[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_w = vals[g];
    end else begin : g_mid_r
      assign right_w = vals[g+1];
    end
    qwir_cell #(
      .CW  (CW),
      .IDX (g)
    ) u_cell (
      .clk      (clk),
      .act      (act),
      .count    (cnt),
      .pos      (pos_c),
      .pick_idx (pick_idx),
      .data_in  (cmd.data_in),
      .pick_in  (pick_word),
      .left     (left_w),
      .right    (right_w),
      .val      (vals[g]),
      .tap      (taps[g])
    );
  end

  always_comb begin
    res_next.data_out  = (act == ACT_POP) ? vals[0] : '0;
    res_next.status    = st;
    res_next.occupancy = OCC_W'(cnt_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      res_valid <= 1'b0;
    end else begin
      cnt <= cnt_next;
      if (cmd_fire) res_valid <= 1'b1;
      else if (!res_stall) res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_fire) res <= res_next;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= FULL_CNT)
    else $error("occupancy above depth");

  a_fire_gives_res: assert property (@(posedge clk) disable iff (rst)
    cmd_fire |=> res_valid)
    else $error("accepted command produced no result");

  a_nochange_keeps_cnt: assert property (@(posedge clk) disable iff (rst)
    cmd_fire && (act == ACT_NONE) |=> cnt == $past(cnt))
    else $error("occupancy moved on a refused or no-op command");

  a_empty_res: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res.status == ST_EMPTY) |-> (res.data_out == '0) && (res.occupancy == '0))
    else $error("empty result carries data or occupancy");

  a_occ_matches: assert property (@(posedge clk) disable iff (rst)
    cmd_fire |=> res.occupancy == OCC_W'(cnt))
    else $error("reported occupancy differs from held count");

endmodule
